// ===== sv/rle_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB LED encoder package
// Shared command codes, register indexes, widths, reset values and the
// helpers that pick the high and low time of one bit.
// ----------------------------------------------------------------------------
package rle_pkg;

    // Command codes carried by the cmd field.
    localparam logic [1:0] CMD_PIXEL = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_ONE_HIGH   = 2'd0;
    localparam logic [1:0] REG_ZERO_HIGH  = 2'd1;
    localparam logic [1:0] REG_BIT_PERIOD = 2'd2;
    localparam logic [1:0] REG_RESET_LOW  = 2'd3;

    // Field and register widths.
    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int PIX_W   = 3 * BYTE_W;
    localparam int TIME_W  = 16;
    localparam int COUNT_W = 20;
    localparam int CFG_W   = COUNT_W;
    localparam int IDX_W   = 2;

    // Bits sent per pixel: default and largest supported value.
    localparam int BITS_PER_PIXEL_DEF = 24;
    localparam int BITS_PER_PIXEL_MAX = 32;

    // Register values after reset.
    localparam logic [TIME_W-1:0]  ONE_HIGH_RST   = 16'd42;
    localparam logic [TIME_W-1:0]  ZERO_HIGH_RST  = 16'd20;
    localparam logic [TIME_W-1:0]  BIT_PERIOD_RST = 16'd62;
    localparam logic [COUNT_W-1:0] RESET_LOW_RST  = 20'd2500;

    // High time of a bit; a zero setting counts as one.
    function automatic logic [TIME_W-1:0] high_time(
        input logic              bit_val,
        input logic [TIME_W-1:0] one_high,
        input logic [TIME_W-1:0] zero_high
    );
        logic [TIME_W-1:0] h;
        h = bit_val ? one_high : zero_high;
        return (h == '0) ? TIME_W'(1) : h;
    endfunction

    // Low time of a bit: the period minus the high time, at least one.
    function automatic logic [TIME_W-1:0] low_time(
        input logic [TIME_W-1:0] period,
        input logic [TIME_W-1:0] high
    );
        return (period > high) ? (period - high) : TIME_W'(1);
    endfunction

endpackage

// ===== sv/rgb_led_single_wire_encoder.sv =====
// ----------------------------------------------------------------------------
// RGB LED single-wire encoder
// Turns pixel and chain-reset commands into the pulse waveform of a
// single-wire LED chain, with each tick item advancing the waveform by one step.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                   | Direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_stall, cmd, red, green, blue | into block
//  result  | out_valid, out_stall, pin_level, busy_res,| out of block
//          | accepted                                  |
//  config  | cfg_write, cfg_index, cfg_data            | into block
//
//  For every item, the waveform state and the result register are both
//  updated at the edge that accepts the item. The result is registered
//  and appears in the cycle after its item is accepted.
//  in_stall is high only while a result is held by out_stall, so items
//  flow at one per cycle whenever the result side keeps up.
//  Reset clears the waveform state and loads the default timings.
// ----------------------------------------------------------------------------
module rgb_led_single_wire_encoder #(
    parameter int BITS_PER_PIXEL = rle_pkg::BITS_PER_PIXEL_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Configuration port
    input  logic                       cfg_write,
    input  logic [rle_pkg::IDX_W-1:0]  cfg_index,
    input  logic [rle_pkg::CFG_W-1:0]  cfg_data,
    // Input channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [rle_pkg::CMD_W-1:0]  cmd,
    input  logic [rle_pkg::BYTE_W-1:0] red,
    input  logic [rle_pkg::BYTE_W-1:0] green,
    input  logic [rle_pkg::BYTE_W-1:0] blue,
    // Result channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       pin_level,
    output logic                       busy_res,
    output logic                       accepted
);

    localparam int BPP    = BITS_PER_PIXEL;
    localparam int BLW    = $clog2(BPP + 1);
    localparam int WIDE_W = rle_pkg::PIX_W + rle_pkg::BITS_PER_PIXEL_MAX;
    localparam int TW     = rle_pkg::TIME_W;
    localparam int CW     = rle_pkg::COUNT_W;

    // Configuration registers.
    logic [TW-1:0] one_high_reg;
    logic [TW-1:0] zero_high_reg;
    logic [TW-1:0] period_reg;
    logic [CW-1:0] reset_low_reg;

    // Waveform state.
    logic [BPP-1:0] shift_reg,  shift_next;
    logic [BLW-1:0] bits_reg,   bits_next;
    logic           high_reg,   high_next;
    logic [CW-1:0]  count_reg,  count_next;
    logic           rsend_reg,  rsend_next;

    // Result register.
    logic out_valid_reg;
    logic pin_reg, pin_next;
    logic busy_reg;
    logic acc_reg, acc_next;

    logic            take;
    logic            busy_now;
    logic            pin_now;
    logic            busy_after;
    logic            pin_after;
    logic [WIDE_W-1:0] pix_wide;
    logic [BPP-1:0]  load_word;
    logic [BPP-1:0]  shifted;
    logic [CW-1:0]   count_dec;
    logic [TW-1:0]   load_high;
    logic [TW-1:0]   next_high;
    logic [TW-1:0]   cur_low;

    // Handshake: hold the input only while a result waits to be taken.
    assign in_stall = out_valid_reg && out_stall;
    assign take     = in_valid && !in_stall;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_high_reg  <= rle_pkg::ONE_HIGH_RST;
            zero_high_reg <= rle_pkg::ZERO_HIGH_RST;
            period_reg    <= rle_pkg::BIT_PERIOD_RST;
            reset_low_reg <= rle_pkg::RESET_LOW_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rle_pkg::REG_ONE_HIGH:   one_high_reg  <= cfg_data[TW-1:0];
                rle_pkg::REG_ZERO_HIGH:  zero_high_reg <= cfg_data[TW-1:0];
                rle_pkg::REG_BIT_PERIOD: period_reg    <= cfg_data[TW-1:0];
                rle_pkg::REG_RESET_LOW:  reset_low_reg <= cfg_data;
                default:                 one_high_reg  <= one_high_reg;
            endcase
        end
    end

    // Current status of the waveform.
    assign busy_now = rsend_reg || (bits_reg != '0);
    assign pin_now  = !rsend_reg && (bits_reg != '0) && high_reg;

    // Pixel word in blue, red, green order, left aligned to the bit count.
    assign pix_wide  = {blue, red, green, {rle_pkg::BITS_PER_PIXEL_MAX{1'b0}}};
    assign load_word = pix_wide[WIDE_W-1 -: BPP];
    assign shifted   = {shift_reg[BPP-2:0], 1'b0};
    assign count_dec = (count_reg == '0) ? '0 : (count_reg - CW'(1));

    // Phase lengths for a load, the next bit and the current low phase.
    assign load_high = rle_pkg::high_time(load_word[BPP-1], one_high_reg, zero_high_reg);
    assign next_high = rle_pkg::high_time(shifted[BPP-1], one_high_reg, zero_high_reg);
    assign cur_low   = rle_pkg::low_time(period_reg,
                           rle_pkg::high_time(shift_reg[BPP-1], one_high_reg,
                                              zero_high_reg));

    // Next waveform state and result for one item.
    always_comb
    begin
        shift_next = shift_reg;
        bits_next  = bits_reg;
        high_next  = high_reg;
        count_next = count_reg;
        rsend_next = rsend_reg;
        acc_next   = 1'b0;
        case (cmd)
            rle_pkg::CMD_PIXEL:
            begin
                if (!busy_now)
                begin
                    shift_next = load_word;
                    bits_next  = BLW'(BPP);
                    high_next  = 1'b1;
                    count_next = {{(CW - TW){1'b0}}, load_high};
                    acc_next   = 1'b1;
                end
            end
            rle_pkg::CMD_RESET:
            begin
                if (!busy_now)
                begin
                    rsend_next = 1'b1;
                    high_next  = 1'b0;
                    count_next = (reset_low_reg == '0) ? CW'(1) : reset_low_reg;
                    acc_next   = 1'b1;
                end
            end
            rle_pkg::CMD_TICK:
            begin
                if (rsend_reg)
                begin
                    count_next = count_dec;
                    if (count_dec == '0)
                    begin
                        rsend_next = 1'b0;
                    end
                end
                else if (bits_reg != '0)
                begin
                    count_next = count_dec;
                    if (count_dec == '0)
                    begin
                        if (high_reg)
                        begin
                            high_next  = 1'b0;
                            count_next = {{(CW - TW){1'b0}}, cur_low};
                        end
                        else
                        begin
                            shift_next = shifted;
                            bits_next  = bits_reg - BLW'(1);
                            if (bits_reg != BLW'(1))
                            begin
                                high_next  = 1'b1;
                                count_next = {{(CW - TW){1'b0}}, next_high};
                            end
                        end
                    end
                end
            end
            default:
            begin
                acc_next = 1'b0;
            end
        endcase
    end

    // Status after the item; a tick reports the level it drove.
    assign busy_after = rsend_next || (bits_next != '0);
    assign pin_after  = !rsend_next && (bits_next != '0) && high_next;
    assign pin_next   = (cmd == rle_pkg::CMD_TICK) ? pin_now : pin_after;

    // Waveform state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            bits_reg  <= '0;
            high_reg  <= 1'b0;
            count_reg <= '0;
            rsend_reg <= 1'b0;
        end
        else if (take)
        begin
            shift_reg <= shift_next;
            bits_reg  <= bits_next;
            high_reg  <= high_next;
            count_reg <= count_next;
            rsend_reg <= rsend_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pin_reg  <= pin_next;
            busy_reg <= busy_after;
            acc_reg  <= acc_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pin_level = pin_reg;
    assign busy_res  = busy_reg;
    assign accepted  = acc_reg;

endmodule

// ===== sv/rle_checker.sv =====
// ----------------------------------------------------------------------------
// RGB LED encoder port checker
// Watches the ports of the encoder and flags results that break its rules.
// ----------------------------------------------------------------------------
module rle_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic [rle_pkg::CMD_W-1:0]  cmd,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic                       pin_level,
    input logic                       busy_res,
    input logic                       accepted
);

    // A result that is held keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pin_level)
            && $stable(busy_res) && $stable(accepted))
        else $error("held result changed");

    // Every accepted item gives a result in the next cycle.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted item produced no result");

    // A taken load leaves the block busy.
    a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> busy_res)
        else $error("load taken but block not busy");

    // The pin is high only within a pixel.
    a_pin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pin_level |-> busy_res)
        else $error("pin high while idle");

    // A tick is never reported as a taken load.
    a_tick_acc: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && cmd == rle_pkg::CMD_TICK |=> !accepted)
        else $error("tick reported as accepted");

endmodule

bind rgb_led_single_wire_encoder rle_checker u_rle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pin_level (pin_level),
    .busy_res  (busy_res),
    .accepted  (accepted)
);

// ===== tb/sv/rgb_led_single_wire_encoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB LED single-wire encoder testbench
// Sends pixel, chain-reset, tick and unused commands through the valid/stall
// input channel under random sender gaps and receiver stalls. A waveform
// model inside the scoreboard predicts pin level, busy flag and load
// acceptance for every item, and each result is checked field by field.
// ----------------------------------------------------------------------------
module rgb_led_single_wire_encoder_tb;

    // Widths taken from the package.
    localparam int CMD_W   = rle_pkg::CMD_W;
    localparam int BYTE_W  = rle_pkg::BYTE_W;
    localparam int TIME_W  = rle_pkg::TIME_W;
    localparam int COUNT_W = rle_pkg::COUNT_W;
    localparam int IDX_W   = rle_pkg::IDX_W;
    localparam int CFG_W   = rle_pkg::CFG_W;

    // The command code the block leaves unused.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int PIXEL_BITS     = rle_pkg::BITS_PER_PIXEL_DEF;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int END_WAIT       = 8;
    localparam int DEFAULT_TICKS  = 130;
    localparam int ROUNDS         = 6;
    localparam int ROUND_ITEMS    = 120;
    localparam int END_TICKS      = 50;

    typedef struct packed {
        logic pin;
        logic busy;
        logic taken;
    } led_result_t;

    // Scoreboard: a cycle-level model of the pulse waveform plus the queue of
    // results it has predicted but not yet seen.
    class led_wave_scoreboard;
        logic [TIME_W-1:0]  one_high;
        logic [TIME_W-1:0]  zero_high;
        logic [TIME_W-1:0]  period;
        logic [COUNT_W-1:0] reset_low;
        logic [31:0]        word;
        int unsigned        bits_left;
        bit                 high_phase;
        int unsigned        phase_left;
        bit                 in_reset;
        led_result_t        pin_reports_due[$];
        int                 errors;

        function new();
            one_high   = rle_pkg::ONE_HIGH_RST;
            zero_high  = rle_pkg::ZERO_HIGH_RST;
            period     = rle_pkg::BIT_PERIOD_RST;
            reset_low  = rle_pkg::RESET_LOW_RST;
            word       = '0;
            bits_left  = 0;
            high_phase = 0;
            phase_left = 0;
            in_reset   = 0;
            errors     = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                rle_pkg::REG_ONE_HIGH:   one_high  = value[TIME_W-1:0];
                rle_pkg::REG_ZERO_HIGH:  zero_high = value[TIME_W-1:0];
                rle_pkg::REG_BIT_PERIOD: period    = value[TIME_W-1:0];
                rle_pkg::REG_RESET_LOW:  reset_low = value;
                default:                 reset_low = reset_low;
            endcase
        endfunction

        // High time of the bit now at the top of the word, never below one.
        function int unsigned high_cycles();
            int unsigned h;
            h = word[31] ? one_high : zero_high;
            return (h == 0) ? 1 : h;
        endfunction

        // The rest of the bit period, with a floor of one.
        function int unsigned low_cycles();
            int unsigned h;
            h = high_cycles();
            return (period > h) ? period - h : 1;
        endfunction

        function bit busy();
            return in_reset || bits_left != 0;
        endfunction

        function logic pin_now();
            return !in_reset && bits_left != 0 && high_phase;
        endfunction

        // Advance the model by one accepted item and queue its result.
        function led_result_t take_command(logic [CMD_W-1:0] c, logic [BYTE_W-1:0] r,
                                           logic [BYTE_W-1:0] g, logic [BYTE_W-1:0] b);
            led_result_t res;
            res = '0;
            case (c)
                rle_pkg::CMD_PIXEL:
                begin
                    if (!busy())
                    begin
                        word       = {b, r, g, 8'h00};
                        bits_left  = PIXEL_BITS;
                        high_phase = 1;
                        phase_left = high_cycles();
                        res.taken  = 1'b1;
                    end
                    res.pin = pin_now();
                end
                rle_pkg::CMD_RESET:
                begin
                    if (!busy())
                    begin
                        in_reset   = 1;
                        high_phase = 0;
                        phase_left = (reset_low == 0) ? 1 : reset_low;
                        res.taken  = 1'b1;
                    end
                    res.pin = pin_now();
                end
                rle_pkg::CMD_TICK:
                begin
                    res.pin = pin_now();
                    if (in_reset)
                    begin
                        if (phase_left > 0)
                            phase_left--;
                        if (phase_left == 0)
                            in_reset = 0;
                    end
                    else if (bits_left != 0)
                    begin
                        if (phase_left > 0)
                            phase_left--;
                        if (phase_left == 0)
                        begin
                            if (high_phase)
                            begin
                                high_phase = 0;
                                phase_left = low_cycles();
                            end
                            else
                            begin
                                word = word << 1;
                                bits_left--;
                                if (bits_left != 0)
                                begin
                                    high_phase = 1;
                                    phase_left = high_cycles();
                                end
                            end
                        end
                    end
                end
                default:
                    res.pin = pin_now();
            endcase
            res.busy = busy();
            pin_reports_due.push_back(res);
            return res;
        endfunction

        function void check_bit(string field, logic want, logic got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s expected %0b actual %0b", $time, field, want, got);
            end
        endfunction

        function void compare_result(logic pin, logic busy_now, logic taken);
            led_result_t want;
            if (pin_reports_due.size() == 0)
            begin
                errors++;
                $display("%0t: result arrived with no item outstanding", $time);
                return;
            end
            want = pin_reports_due.pop_front();
            check_bit("pin_level", want.pin, pin);
            check_bit("busy_res", want.busy, busy_now);
            check_bit("accepted", want.taken, taken);
        endfunction
    endclass

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               cfg_write = 1'b0;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [CMD_W-1:0]   cmd       = rle_pkg::CMD_TICK;
    logic [BYTE_W-1:0]  red       = '0;
    logic [BYTE_W-1:0]  green     = '0;
    logic [BYTE_W-1:0]  blue      = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               pin_level;
    logic               busy_res;
    logic               accepted;

    led_wave_scoreboard board = new();

    bit valid_held;
    bit calm;
    int holds_asked;
    int holds_begun;
    int quiet_cycles;
    int settings_used;
    int pixels_sent;
    int resets_sent;
    int loads_refused;
    int ticks_sent;
    int unused_sent;
    int results_seen;
    int long_holds;

    rgb_led_single_wire_encoder #(
        .BITS_PER_PIXEL(PIXEL_BITS)
    ) DUT (.*);

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one item, wait for it to be taken, then idle for a random gap.
    task automatic send_item(logic [CMD_W-1:0] c, logic [BYTE_W-1:0] r,
                             logic [BYTE_W-1:0] g, logic [BYTE_W-1:0] b);
        led_result_t res;
        int roll;
        int gap;
        in_valid <= 1'b1;
        cmd      <= c;
        red      <= r;
        green    <= g;
        blue     <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = board.take_command(c, r, g, b);
        if (c == rle_pkg::CMD_TICK)
            ticks_sent++;
        else if (c == CMD_UNUSED)
            unused_sent++;
        else if (!res.taken)
            loads_refused++;
        else if (c == rle_pkg::CMD_PIXEL)
            pixels_sent++;
        else
            resets_sent++;
        roll = $urandom_range(0, 99);
        if (calm || roll < 80)
            gap = 0;
        else if (roll < 97)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        valid_held = (gap == 0);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Byte with a bias toward all zeros and all ones.
    function automatic logic [BYTE_W-1:0] pick_byte();
        int roll;
        int unsigned value;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 8'h00;
        if (roll < 20)
            return 8'hFF;
        value = $urandom_range(0, 255);
        return value[BYTE_W-1:0];
    endfunction

    // Stop offering items and wait until every predicted result is back.
    task automatic drain_results();
        if (valid_held)
        begin
            in_valid <= 1'b0;
            valid_held = 0;
        end
        do
            @(posedge clk);
        while (board.pin_reports_due.size() != 0);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        board.set_reg(idx, value);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_timing(logic [TIME_W-1:0] one_h, logic [TIME_W-1:0] zero_h,
                              logic [TIME_W-1:0] per, logic [COUNT_W-1:0] rst_low);
        drain_results();
        write_reg(rle_pkg::REG_ONE_HIGH, CFG_W'(one_h));
        write_reg(rle_pkg::REG_ZERO_HIGH, CFG_W'(zero_h));
        write_reg(rle_pkg::REG_BIT_PERIOD, CFG_W'(per));
        write_reg(rle_pkg::REG_RESET_LOW, rst_low);
        settings_used++;
    endtask

    // Ask the result side for a long hold and wait until it has started.
    task automatic start_long_hold();
        drain_results();
        holds_asked++;
        wait (holds_begun == holds_asked);
    endtask

    // Tick until the current pixel or chain reset has finished.
    task automatic run_out();
        while (board.busy())
            send_item(rle_pkg::CMD_TICK, pick_byte(), pick_byte(), pick_byte());
    endtask

    // Mostly complete pixels and resets with random content, with stray
    // loads and unused commands mixed into the ticks.
    task automatic random_round(int budget);
        int used;
        int roll;
        used = 0;
        while (used < budget)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
                send_item(rle_pkg::CMD_PIXEL, pick_byte(), pick_byte(), pick_byte());
            else if (roll < 85)
                send_item(rle_pkg::CMD_RESET, pick_byte(), pick_byte(), pick_byte());
            else if (roll < 93)
                send_item(CMD_UNUSED, pick_byte(), pick_byte(), pick_byte());
            else
                send_item(rle_pkg::CMD_TICK, pick_byte(), pick_byte(), pick_byte());
            used++;
            while (board.busy() && used < budget)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 92)
                    send_item(rle_pkg::CMD_TICK, pick_byte(), pick_byte(), pick_byte());
                else if (roll < 96)
                    send_item(rle_pkg::CMD_PIXEL, pick_byte(), pick_byte(), pick_byte());
                else if (roll < 98)
                    send_item(rle_pkg::CMD_RESET, pick_byte(), pick_byte(), pick_byte());
                else
                    send_item(CMD_UNUSED, pick_byte(), pick_byte(), pick_byte());
                used++;
            end
        end
    endtask

    // Result side: random stalls, free-running stretches and, on request,
    // one long hold that backs the block up into its input.
    initial
    begin
        int roll;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_holds < holds_asked)
            begin
                out_stall <= 1'b1;
                holds_begun++;
                repeat (LONG_HOLD) @(posedge clk);
                long_holds++;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                begin
                    out_stall <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
                else if (roll < 90)
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else if (roll < 96)
                begin
                    out_stall <= 1'b0;
                    repeat ($urandom_range(100, 300)) @(posedge clk);
                end
                else
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(10, 40)) @(posedge clk);
                end
            end
        end
    end

    // Check every result taken from the block.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            board.compare_result(pin_level, busy_res, accepted);
            results_seen++;
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("rgb_led_single_wire_encoder_tb failed");
            $finish;
        end
    end

    // Stimulus.
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default timings: idle commands, then one pixel with loads refused
        // while it plays and its first bits. The result side holds off while
        // these items are offered.
        send_item(rle_pkg::CMD_TICK, 8'hFF, 8'h00, 8'hFF);
        send_item(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF);
        start_long_hold();
        send_item(rle_pkg::CMD_PIXEL, 8'h00, 8'hA5, 8'hFF);
        send_item(rle_pkg::CMD_PIXEL, 8'hFF, 8'hFF, 8'h00);
        send_item(rle_pkg::CMD_RESET, 8'h00, 8'h00, 8'h00);
        send_item(CMD_UNUSED, 8'h00, 8'h00, 8'h00);
        repeat (DEFAULT_TICKS) send_item(rle_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00);

        // Short timings, written while that pixel plays, so it ends at the
        // new rates. Then a chain reset that refuses a pixel, all ones, all
        // zeros and a pattern that shows the blue, red, green byte order.
        set_timing(3, 1, 5, 4);
        run_out();
        send_item(rle_pkg::CMD_RESET, 8'h12, 8'h34, 8'h56);
        send_item(rle_pkg::CMD_PIXEL, 8'h12, 8'h34, 8'h56);
        run_out();
        send_item(rle_pkg::CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        run_out();
        send_item(rle_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00);
        run_out();
        send_item(rle_pkg::CMD_PIXEL, 8'h5A, 8'hC3, 8'h3C);
        run_out();
        send_item(rle_pkg::CMD_RESET, 8'h00, 8'h00, 8'h00);
        run_out();

        // Zero timing registers count as one.
        set_timing(0, 0, 0, 0);
        send_item(rle_pkg::CMD_PIXEL, 8'h0F, 8'hF0, 8'h96);
        run_out();
        send_item(rle_pkg::CMD_RESET, 8'h00, 8'h00, 8'h00);
        run_out();

        // Bit period shorter than the high time: low time floors at one.
        set_timing(6, 2, 4, 1);
        send_item(rle_pkg::CMD_PIXEL, 8'h81, 8'h18, 8'hE7);
        run_out();

        // Timings changed in the middle of a pixel.
        set_timing(2, 1, 4, 3);
        send_item(rle_pkg::CMD_PIXEL, 8'hAA, 8'h55, 8'hC0);
        repeat (20) send_item(rle_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00);
        set_timing(1, 3, 7, 2);
        run_out();

        // Random rounds, each under new short timings.
        for (int k = 0; k < ROUNDS; k++)
        begin
            calm = ($urandom_range(0, 3) == 0);
            set_timing(TIME_W'($urandom_range(0, 3)), TIME_W'($urandom_range(0, 3)),
                       TIME_W'($urandom_range(0, 6)), COUNT_W'($urandom_range(0, 10)));
            random_round(ROUND_ITEMS);
        end
        run_out();

        // Data bits above the width of a narrow register are dropped.
        drain_results();
        write_reg(rle_pkg::REG_ONE_HIGH, 20'hF0003);
        write_reg(rle_pkg::REG_ZERO_HIGH, 20'hA0002);
        write_reg(rle_pkg::REG_BIT_PERIOD, 20'h50005);
        write_reg(rle_pkg::REG_RESET_LOW, 20'h00007);
        settings_used++;
        send_item(rle_pkg::CMD_PIXEL, 8'h5A, 8'hC3, 8'h3C);
        run_out();
        send_item(rle_pkg::CMD_RESET, 8'h00, 8'h00, 8'h00);
        run_out();

        // Full-scale timings: a pixel with the longest high time refuses a
        // chain reset, and the run ends while its first bit is still high.
        calm = 1;
        set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
        start_long_hold();
        send_item(rle_pkg::CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_item(rle_pkg::CMD_RESET, 8'h00, 8'h00, 8'h00);
        repeat (END_TICKS) send_item(rle_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00);

        drain_results();
        repeat (END_WAIT) @(posedge clk);

        $display("Covered %0d pixels, %0d chain resets, %0d refused loads,",
                 pixels_sent, resets_sent, loads_refused);
        $display("%0d ticks and %0d unused commands; checked %0d results over %0d timing settings with %0d long result holds.",
                 ticks_sent, unused_sent, results_seen, settings_used, long_holds);
        if (board.errors == 0)
            $display("rgb_led_single_wire_encoder_tb passed");
        else
            $display("rgb_led_single_wire_encoder_tb failed");
        $finish;
    end

endmodule
